@@ src/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the frame parser RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled during reset.
`define VPFP_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Clocked assertion that is also checked while reset is high.
`define VPFP_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

@@ src/vpfp_pkg.sv @@
// ----------------------------------------------------------------------------
// vpfp_pkg
// Types and constants shared by the serial frame parser modules.
// ----------------------------------------------------------------------------
package vpfp_pkg;

  localparam int MAX_BODY_LEN_DEF = 9;

  localparam int BYTE_W = 8;
  localparam int WORD_W = 16;
  localparam int LEN_W  = 4;

  localparam logic [BYTE_W-1:0] HDR_FIRST     = 8'h5A;
  localparam logic [BYTE_W-1:0] HDR_SECOND    = 8'hA5;
  localparam logic [BYTE_W-1:0] CMD_WRITE     = 8'h82;
  localparam logic [BYTE_W-1:0] CMD_READ_RESP = 8'h83;

  // Only the first six body bytes are ever looked at
  localparam int MIN_VALUE_LEN = 6;
  localparam int BODY_IDX_W    = $clog2(MIN_VALUE_LEN);

  // Body byte positions
  localparam int BI_CMD     = 0;
  localparam int BI_ADDR_HI = 1;
  localparam int BI_ADDR_LO = 2;
  localparam int BI_VAL_HI  = 4;
  localparam int BI_VAL_LO  = 5;

  typedef enum logic [3:0] {
    PH_IDLE       = 4'b0001,
    PH_GOT_FIRST  = 4'b0010,
    PH_GOT_SECOND = 4'b0100,
    PH_BODY       = 4'b1000
  } phase_t;

  typedef struct packed {
    logic [WORD_W-1:0] address;
    logic [WORD_W-1:0] value;
    logic              is_write;
  } result_t;

endpackage

@@ src/vpfp_parser.sv @@
// ----------------------------------------------------------------------------
// vpfp_parser
// Frame hunting state machine and body store; one byte per step.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module vpfp_parser #(
  parameter int MAX_BODY_LEN = vpfp_pkg::MAX_BODY_LEN_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        step,
  input  logic [vpfp_pkg::BYTE_W-1:0] byte_in,
  output logic                        res_valid,
  output vpfp_pkg::result_t           res
);

  vpfp_pkg::phase_t phase, phase_next;
  logic [vpfp_pkg::LEN_W-1:0] byte_count, byte_count_next;
  logic [vpfp_pkg::LEN_W-1:0] body_length, body_length_next;
  logic [vpfp_pkg::BYTE_W-1:0] body_store [vpfp_pkg::MIN_VALUE_LEN];

  logic [vpfp_pkg::LEN_W-1:0]  count_inc;
  logic                        last_byte;
  logic                        len_ok;
  logic                        cmd_ok;
  logic [vpfp_pkg::BYTE_W-1:0] cmd;
  logic [vpfp_pkg::BYTE_W-1:0] val_lo;

  assign count_inc = byte_count + 1'b1;
  assign last_byte = (count_inc >= body_length);
  assign len_ok    = (byte_in != '0) &&
                     (byte_in <= vpfp_pkg::BYTE_W'(MAX_BODY_LEN));

  assign cmd    = body_store[vpfp_pkg::BI_CMD];
  assign cmd_ok = (cmd == vpfp_pkg::CMD_WRITE) || (cmd == vpfp_pkg::CMD_READ_RESP);
  // with the shortest valid frame the value low byte is the one arriving now
  assign val_lo = (byte_count == vpfp_pkg::LEN_W'(vpfp_pkg::BI_VAL_LO)) ?
                  byte_in : body_store[vpfp_pkg::BI_VAL_LO];

  assign res.address  = {body_store[vpfp_pkg::BI_ADDR_HI],
                         body_store[vpfp_pkg::BI_ADDR_LO]};
  assign res.value    = {body_store[vpfp_pkg::BI_VAL_HI], val_lo};
  assign res.is_write = (cmd == vpfp_pkg::CMD_WRITE);

  always_comb begin
    phase_next       = phase;
    byte_count_next  = byte_count;
    body_length_next = body_length;
    res_valid        = 1'b0;
    unique case (phase)
      vpfp_pkg::PH_IDLE: begin
        if (byte_in == vpfp_pkg::HDR_FIRST) phase_next = vpfp_pkg::PH_GOT_FIRST;
      end
      vpfp_pkg::PH_GOT_FIRST: begin
        if (byte_in == vpfp_pkg::HDR_SECOND) begin
          phase_next = vpfp_pkg::PH_GOT_SECOND;
        end else if (byte_in != vpfp_pkg::HDR_FIRST) begin
          phase_next = vpfp_pkg::PH_IDLE;
        end
      end
      vpfp_pkg::PH_GOT_SECOND: begin
        if (len_ok) begin
          body_length_next = byte_in[vpfp_pkg::LEN_W-1:0];
          byte_count_next  = '0;
          phase_next       = vpfp_pkg::PH_BODY;
        end else begin
          phase_next = vpfp_pkg::PH_IDLE;
        end
      end
      vpfp_pkg::PH_BODY: begin
        byte_count_next = count_inc;
        if (last_byte) begin
          phase_next = vpfp_pkg::PH_IDLE;
          res_valid  = cmd_ok &&
                       (body_length >= vpfp_pkg::LEN_W'(vpfp_pkg::MIN_VALUE_LEN));
        end
      end
      default: phase_next = vpfp_pkg::PH_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= vpfp_pkg::PH_IDLE;
      byte_count  <= '0;
      body_length <= '0;
    end else if (step) begin
      phase       <= phase_next;
      byte_count  <= byte_count_next;
      body_length <= body_length_next;
    end
  end

  // bytes past the sixth are counted only
  always_ff @(posedge clk) begin
    if (step && (phase == vpfp_pkg::PH_BODY) &&
        (byte_count < vpfp_pkg::LEN_W'(vpfp_pkg::MIN_VALUE_LEN))) begin
      body_store[byte_count[vpfp_pkg::BODY_IDX_W-1:0]] <= byte_in;
    end
  end

  `VPFP_ASSERT(a_res_only_in_body, res_valid |-> (phase == vpfp_pkg::PH_BODY), "result outside body")
  `VPFP_ASSERT(a_count_below_len, (phase == vpfp_pkg::PH_BODY) |-> (byte_count < body_length), "byte count overran length")
  `VPFP_ASSERT(a_len_in_range, (phase == vpfp_pkg::PH_BODY) |-> ((body_length != '0) && (body_length <= vpfp_pkg::LEN_W'(MAX_BODY_LEN))), "body length out of range")

endmodule

@@ src/display_vp_frame_parser_core.sv @@
// ----------------------------------------------------------------------------
// display_vp_frame_parser_core
// Serial frame parser: hunts 5A A5 L body frames, emits address and value.
// ----------------------------------------------------------------------------
//  channel  handshake          payload
//  in       in_valid/in_ready  rx_byte
//  out      out_valid/out_ready frame_address, frame_value, is_write_cmd
//
// One byte per cycle sustained while the output is not stalled; a frame's last
// byte passes the input register and then, when the parser steps, the result
// register that raises out_valid.
// The parser advances only when the result register is free or being read,
// so a stalled output holds the input register and then in_ready.
// rst is synchronous; it returns the parser to the hunting state at once.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module display_vp_frame_parser_core #(
  parameter int MAX_BODY_LEN = vpfp_pkg::MAX_BODY_LEN_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [vpfp_pkg::BYTE_W-1:0] rx_byte,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [vpfp_pkg::WORD_W-1:0] frame_address,
  output logic [vpfp_pkg::WORD_W-1:0] frame_value,
  output logic                        is_write_cmd
);

  logic                        in_full;
  logic [vpfp_pkg::BYTE_W-1:0] in_byte;
  logic                        step;
  logic                        res_valid;
  vpfp_pkg::result_t           res;
  vpfp_pkg::result_t           out_res;

  assign step     = in_full && (!out_valid || out_ready);
  assign in_ready = !in_full || step;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_ready) begin
      in_full <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) in_byte <= rx_byte;
  end

  vpfp_parser #(
    .MAX_BODY_LEN(MAX_BODY_LEN)
  ) u_parser (
    .clk      (clk),
    .rst      (rst),
    .step     (step),
    .byte_in  (in_byte),
    .res_valid(res_valid),
    .res      (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step) begin
      out_valid <= res_valid;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step && res_valid) out_res <= res;
  end

  assign frame_address = out_res.address;
  assign frame_value   = out_res.value;
  assign is_write_cmd  = out_res.is_write;

  `VPFP_ASSERT(a_ready_when_out_free, !out_valid |-> in_ready, "input stalled with empty output")
  `VPFP_ASSERT(a_result_lands, (step && res_valid) |=> out_valid, "result not registered")

endmodule

@@ sim/vpfp_result_checker.sv @@
// ----------------------------------------------------------------------------
// vpfp_result_checker
// Watches both channels of the frame parser, tracks the frame hunt for every
// accepted byte and compares each accepted result with the oldest one due.
// ----------------------------------------------------------------------------
module vpfp_result_checker #(
  parameter int MAX_BODY_LEN = vpfp_pkg::MAX_BODY_LEN_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [7:0]  rx_byte,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [15:0] frame_address,
  input  logic [15:0] frame_value,
  input  logic        is_write_cmd,
  output int          mismatch_count,
  output int          results_pending
);
  import vpfp_pkg::*;

  localparam int STORE_DEPTH = 12;
  localparam int BODY_OFS    = 3;   // store entries 0..2 hold 5A, A5, length

  phase_t     hunt_phase;
  logic [3:0] body_count;
  logic [3:0] body_len;
  logic [7:0] frame_bytes [STORE_DEPTH];
  result_t    expected_results [$];

  initial begin
    mismatch_count  = 0;
    results_pending = 0;
  end

  task automatic report_mismatch(input string what);
    $display("[%0t] frame result mismatch: %s", $time, what);
    mismatch_count++;
  endtask

  task automatic parse_byte(input logic [7:0] b);
    result_t    res;
    logic [7:0] cmd;
    case (hunt_phase)
      PH_IDLE: begin
        if (b == HDR_FIRST) begin
          frame_bytes[0] = b;
          hunt_phase = PH_GOT_FIRST;
        end
      end
      PH_GOT_FIRST: begin
        if (b == HDR_SECOND) begin
          frame_bytes[1] = b;
          hunt_phase = PH_GOT_SECOND;
        end else if (b == HDR_FIRST) begin
          frame_bytes[0] = b;
        end else begin
          hunt_phase = PH_IDLE;
        end
      end
      PH_GOT_SECOND: begin
        frame_bytes[2] = b;
        if (b != 8'd0 && b <= MAX_BODY_LEN && b <= 15) begin
          body_len   = b[3:0];
          body_count = 4'd0;
          hunt_phase = PH_BODY;
        end else begin
          hunt_phase = PH_IDLE;
        end
      end
      default: begin
        // header bytes in the body are plain data; no resync
        if (BODY_OFS + body_count < STORE_DEPTH) frame_bytes[BODY_OFS + body_count] = b;
        body_count = body_count + 4'd1;
        if (body_count >= body_len) begin
          cmd = frame_bytes[BODY_OFS + BI_CMD];
          if ((cmd == CMD_WRITE || cmd == CMD_READ_RESP) && body_len >= MIN_VALUE_LEN) begin
            res.address  = {frame_bytes[BODY_OFS + BI_ADDR_HI],
                            frame_bytes[BODY_OFS + BI_ADDR_LO]};
            res.value    = {frame_bytes[BODY_OFS + BI_VAL_HI],
                            frame_bytes[BODY_OFS + BI_VAL_LO]};
            res.is_write = (cmd == CMD_WRITE);
            expected_results.push_back(res);
          end
          hunt_phase = PH_IDLE;
        end
      end
    endcase
  endtask

  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      hunt_phase = PH_IDLE;
      body_count = 4'd0;
      body_len   = 4'd0;
      expected_results.delete();
    end else begin
      // a result always trails its last byte, so checking first is safe
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          report_mismatch($sformatf("unexpected result address %h value %h write %b",
                                    frame_address, frame_value, is_write_cmd));
        end else begin
          want = expected_results.pop_front();
          if (frame_address !== want.address)
            report_mismatch($sformatf("frame_address %h, expected %h",
                                      frame_address, want.address));
          if (frame_value !== want.value)
            report_mismatch($sformatf("frame_value %h, expected %h",
                                      frame_value, want.value));
          if (is_write_cmd !== want.is_write)
            report_mismatch($sformatf("is_write_cmd %b, expected %b",
                                      is_write_cmd, want.is_write));
        end
      end
      if (in_valid && in_ready) parse_byte(rx_byte);
    end
    results_pending = expected_results.size();
  end

endmodule

@@ sim/tb_display_vp_frame_parser_core.sv @@
// ----------------------------------------------------------------------------
// tb_display_vp_frame_parser_core
// Feeds the frame parser directed and random byte streams under several
// idle and stall mixes, including one long output hold-off; the checker
// beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_display_vp_frame_parser_core;
  import vpfp_pkg::*;

  localparam int BODY_MAX    = MAX_BODY_LEN_DEF;
  localparam int HOLD_CYCLES = 80;
  localparam int PHASE_BYTES = 170;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  rx_byte;
  logic        out_valid;
  logic        out_ready;
  logic [15:0] frame_address;
  logic [15:0] frame_value;
  logic        is_write_cmd;
  int          mismatches;
  int          pending;

  int   bytes_sent     = 0;
  int   send_idle_pct  = 0;
  int   recv_stall_pct = 0;
  logic hold_req       = 1'b0;
  logic hold_seen      = 1'b0;
  logic [7:0] directed_seq [$];

  display_vp_frame_parser_core #(.MAX_BODY_LEN(BODY_MAX)) dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .rx_byte      (rx_byte),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .frame_address(frame_address),
    .frame_value  (frame_value),
    .is_write_cmd (is_write_cmd)
  );

  vpfp_result_checker #(.MAX_BODY_LEN(BODY_MAX)) u_result_check (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .rx_byte        (rx_byte),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .frame_address  (frame_address),
    .frame_value    (frame_value),
    .is_write_cmd   (is_write_cmd),
    .mismatch_count (mismatches),
    .results_pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #200000;
    $display("Verification failed");
    $finish;
  end

  // Receiver: random stalls, plus one long hold-off on request
  initial begin
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req != hold_seen) begin
        hold_seen = hold_req;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  function automatic logic [7:0] pick_byte();
    int r;
    r = $urandom_range(0, 9);
    case (r)
      0:       return HDR_FIRST;
      1:       return HDR_SECOND;
      2:       return 8'h00;
      3:       return 8'hFF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [7:0] pick_cmd();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return CMD_WRITE;
    if (r < 90) return CMD_READ_RESP;
    return pick_byte();
  endfunction

  // Called at a rising edge; returns at the edge that accepted the item,
  // or after the idle cycles that follow it
  task automatic send_byte(input logic [7:0] b);
    in_valid <= 1'b1;
    rx_byte  <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    bytes_sent++;
    // each following cycle idles with the given odds
    while (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
  endtask

  task automatic send_frame(input logic [7:0] len, input logic [7:0] cmd);
    send_byte(HDR_FIRST);
    send_byte(HDR_SECOND);
    send_byte(len);
    send_byte(cmd);
    for (int i = 1; i < len; i++) send_byte(pick_byte());
  endtask

  task automatic send_random_unit();
    int r;
    int n;
    r = $urandom_range(0, 99);
    if (r < 65) begin
      send_frame(8'($urandom_range(MIN_VALUE_LEN, BODY_MAX)), pick_cmd());
    end else if (r < 77) begin
      send_frame(8'($urandom_range(1, MIN_VALUE_LEN - 1)), pick_cmd());
    end else if (r < 85) begin
      send_byte(HDR_FIRST);
      send_byte(HDR_SECOND);
      if ($urandom_range(0, 1) == 0) send_byte(8'h00);
      else send_byte(8'($urandom_range(BODY_MAX + 1, 255)));
    end else if (r < 92) begin
      // broken header, sometimes with repeated first bytes
      n = $urandom_range(1, 3);
      repeat (n) send_byte(HDR_FIRST);
      send_byte(pick_byte());
    end else begin
      n = $urandom_range(1, 4);
      repeat (n) send_byte(pick_byte());
    end
  endtask

  task automatic run_phase(input int idle_pct, input int stall_pct, input int n_bytes);
    int target;
    target         = bytes_sent + n_bytes;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    while (bytes_sent < target) send_random_unit();
  endtask

  initial begin
    int drain;
    rst      <= 1'b1;
    in_valid <= 1'b0;
    rx_byte  <= 8'h00;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // repeated header, longest read-response with header bytes in its body,
    // shortest write, other byte after 5A, lengths zero and 255, short frame
    directed_seq = '{HDR_FIRST, HDR_FIRST, HDR_SECOND, 8'd9, CMD_READ_RESP,
                     8'hFF, 8'hFF, 8'h00, HDR_FIRST, HDR_SECOND, 8'h80, 8'h7F, 8'h01,
                     HDR_FIRST, HDR_SECOND, 8'd6, CMD_WRITE,
                     8'h00, 8'h00, HDR_SECOND, 8'h00, 8'h00,
                     HDR_FIRST, 8'h01,
                     HDR_FIRST, HDR_SECOND, 8'h00,
                     HDR_FIRST, HDR_SECOND, 8'hFF,
                     HDR_FIRST, HDR_SECOND, 8'd1, CMD_WRITE};
    foreach (directed_seq[i]) send_byte(directed_seq[i]);

    run_phase(0, 0, PHASE_BYTES);
    run_phase(62, 0, PHASE_BYTES);
    run_phase(0, 62, PHASE_BYTES);
    run_phase(23, 23, PHASE_BYTES);

    // long output hold-off while frames keep coming: input must back up
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_req = ~hold_req;
    repeat (8) send_frame(8'(MIN_VALUE_LEN), pick_cmd());

    in_valid <= 1'b0;
    recv_stall_pct = 0;
    repeat (4) @(posedge clk);
    drain = 0;
    while (pending != 0 && drain < 4000) begin
      @(posedge clk);
      drain++;
    end
    repeat (8) @(posedge clk);

    if (mismatches == 0 && pending == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
